// ===== hw/rtl/lpr_pkg.sv =====
package lpr_pkg;

  localparam int unsigned IdW    = 7;
  localparam int unsigned CountW = 8;
  localparam int unsigned RoundW = 7;
  localparam int unsigned StepW  = 4;

  localparam logic [CountW-1:0] CountReset = 8'd128;
  localparam logic [RoundW-1:0] RoundMax   = 7'd127;

  typedef struct packed {
    logic [IdW-1:0] endpoint_a;
    logic [IdW-1:0] endpoint_b;
    logic           edge_present;
    logic           last_item;
  } item_t;

  typedef struct packed {
    logic [RoundW-1:0] round_count;
    logic              bad_input;
  } result_t;

  typedef enum logic [3:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NO_REQ,
    COND_EDGE_SKIP,
    COND_NOT_LAST,
    COND_ROUND_LIMIT,
    COND_SCAN_DONE,
    COND_NOT_ELIG,
    COND_NONE_REMOVED,
    COND_OUT_BUSY,
    COND_CLR_MORE
  } cond_e;

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_V,
    RD_X
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR,
    WR_A,
    WR_B,
    WR_X,
    WR_V
  } wr_sel_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR_INC,
    OP_ROUND_INIT,
    OP_LATCH_X,
    OP_V_INC,
    OP_ROUND_INC,
    OP_EMIT,
    OP_RESTART
  } op_e;

  typedef struct packed {
    cond_e            cond;
    logic [StepW-1:0] target;
    rd_sel_e          rd;
    wr_sel_e          wr;
    op_e              op;
  } ctrl_t;

  typedef struct packed {
    logic no_req;
    logic edge_skip;
    logic not_last;
    logic round_limit;
    logic scan_done;
    logic not_elig;
    logic none_removed;
    logic out_busy;
    logic clr_more;
  } flags_t;

endpackage

// ===== hw/rtl/leaf_peeling_round_counter.sv =====
// Leaf peeling round counter.
// Input channel (in_valid_i/in_ready_o/in_data_i): one request per edge.
// Requests with edge_present low only carry last_item; last_item ends the
// graph and starts peeling. Bad edges (id not below the vertex count, or a
// self-loop) are dropped and reported in bad_input.
// Output channel (out_valid_o/out_ready_i/out_data_o): one result per graph.
// cfg_we_i/cfg_data_i write the vertex count; write it only while idle.
// After the last request, peeling runs in rounds that scan every vertex,
// ending with the first round that removes nothing or at the round limit.
// The result is then loaded into the output register once it is free, and
// a restart step and a clear pass of the vertex store run before the next
// request is taken.
// Reset starts the same clear pass of the vertex store; in_ready_o is
// low throughout it. The result sits in an output register: the next graph
// loads while it waits, and the sequencer holds the following result until
// the receiver has taken the earlier one.
module leaf_peeling_round_counter #(
  parameter int unsigned MAX_VERTICES = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lpr_pkg::item_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lpr_pkg::result_t           out_data_o,
  input  logic                       cfg_we_i,
  input  logic [lpr_pkg::CountW-1:0] cfg_data_i
);

  lpr_pkg::ctrl_t  ctrl;
  lpr_pkg::flags_t flags;

  lpr_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  lpr_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .flags_o     (flags),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

// ===== hw/rtl/lpr_useq.sv =====
module lpr_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lpr_pkg::flags_t flags_i,
  output lpr_pkg::ctrl_t  ctrl_o
);

  localparam int unsigned StepW = lpr_pkg::StepW;

  localparam logic [StepW-1:0] StClr      = 4'd0;
  localparam logic [StepW-1:0] StIdle     = 4'd1;
  localparam logic [StepW-1:0] StLdA      = 4'd2;
  localparam logic [StepW-1:0] StLdAWr    = 4'd3;
  localparam logic [StepW-1:0] StLdBWr    = 4'd4;
  localparam logic [StepW-1:0] StChkLast  = 4'd5;
  localparam logic [StepW-1:0] StRndStart = 4'd6;
  localparam logic [StepW-1:0] StScanRd   = 4'd7;
  localparam logic [StepW-1:0] StEval     = 4'd8;
  localparam logic [StepW-1:0] StXWr      = 4'd9;
  localparam logic [StepW-1:0] StVWr      = 4'd10;
  localparam logic [StepW-1:0] StNextV    = 4'd11;
  localparam logic [StepW-1:0] StRndEnd   = 4'd12;
  localparam logic [StepW-1:0] StRndNext  = 4'd13;
  localparam logic [StepW-1:0] StEmit     = 4'd14;
  localparam logic [StepW-1:0] StRestart  = 4'd15;

  function automatic lpr_pkg::ctrl_t cw(input lpr_pkg::cond_e cond,
                                        input logic [StepW-1:0] target,
                                        input lpr_pkg::rd_sel_e rd,
                                        input lpr_pkg::wr_sel_e wr,
                                        input lpr_pkg::op_e op);
    lpr_pkg::ctrl_t w;
    w.cond   = cond;
    w.target = target;
    w.rd     = rd;
    w.wr     = wr;
    w.op     = op;
    return w;
  endfunction

  // control store
  function automatic lpr_pkg::ctrl_t ucode(input logic [StepW-1:0] step);
    lpr_pkg::ctrl_t w;
    unique case (step)
      StClr:      w = cw(lpr_pkg::COND_CLR_MORE, StClr, lpr_pkg::RD_V,
                         lpr_pkg::WR_CLR, lpr_pkg::OP_CLR_INC);
      StIdle:     w = cw(lpr_pkg::COND_NO_REQ, StIdle, lpr_pkg::RD_A,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_ACCEPT);
      StLdA:      w = cw(lpr_pkg::COND_EDGE_SKIP, StChkLast, lpr_pkg::RD_A,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_NONE);
      StLdAWr:    w = cw(lpr_pkg::COND_NEVER, StLdAWr, lpr_pkg::RD_B,
                         lpr_pkg::WR_A, lpr_pkg::OP_NONE);
      StLdBWr:    w = cw(lpr_pkg::COND_NEVER, StLdBWr, lpr_pkg::RD_B,
                         lpr_pkg::WR_B, lpr_pkg::OP_NONE);
      StChkLast:  w = cw(lpr_pkg::COND_NOT_LAST, StIdle, lpr_pkg::RD_V,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_NONE);
      StRndStart: w = cw(lpr_pkg::COND_ROUND_LIMIT, StEmit, lpr_pkg::RD_V,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_ROUND_INIT);
      StScanRd:   w = cw(lpr_pkg::COND_SCAN_DONE, StRndEnd, lpr_pkg::RD_V,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_NONE);
      StEval:     w = cw(lpr_pkg::COND_NOT_ELIG, StNextV, lpr_pkg::RD_X,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_LATCH_X);
      StXWr:      w = cw(lpr_pkg::COND_NEVER, StXWr, lpr_pkg::RD_V,
                         lpr_pkg::WR_X, lpr_pkg::OP_NONE);
      StVWr:      w = cw(lpr_pkg::COND_NEVER, StVWr, lpr_pkg::RD_V,
                         lpr_pkg::WR_V, lpr_pkg::OP_NONE);
      StNextV:    w = cw(lpr_pkg::COND_ALWAYS, StScanRd, lpr_pkg::RD_V,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_V_INC);
      StRndEnd:   w = cw(lpr_pkg::COND_NONE_REMOVED, StEmit, lpr_pkg::RD_V,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_NONE);
      StRndNext:  w = cw(lpr_pkg::COND_ALWAYS, StRndStart, lpr_pkg::RD_V,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_ROUND_INC);
      StEmit:     w = cw(lpr_pkg::COND_OUT_BUSY, StEmit, lpr_pkg::RD_V,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_EMIT);
      StRestart:  w = cw(lpr_pkg::COND_ALWAYS, StClr, lpr_pkg::RD_V,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_RESTART);
      default:    w = cw(lpr_pkg::COND_ALWAYS, StClr, lpr_pkg::RD_V,
                         lpr_pkg::WR_NONE, lpr_pkg::OP_NONE);
    endcase
    return w;
  endfunction

  logic [StepW-1:0] pc_q, pc_d;
  lpr_pkg::ctrl_t   ctrl;
  logic             take;

  assign ctrl   = ucode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.cond)
      lpr_pkg::COND_ALWAYS:       take = 1'b1;
      lpr_pkg::COND_NEVER:        take = 1'b0;
      lpr_pkg::COND_NO_REQ:       take = flags_i.no_req;
      lpr_pkg::COND_EDGE_SKIP:    take = flags_i.edge_skip;
      lpr_pkg::COND_NOT_LAST:     take = flags_i.not_last;
      lpr_pkg::COND_ROUND_LIMIT:  take = flags_i.round_limit;
      lpr_pkg::COND_SCAN_DONE:    take = flags_i.scan_done;
      lpr_pkg::COND_NOT_ELIG:     take = flags_i.not_elig;
      lpr_pkg::COND_NONE_REMOVED: take = flags_i.none_removed;
      lpr_pkg::COND_OUT_BUSY:     take = flags_i.out_busy;
      lpr_pkg::COND_CLR_MORE:     take = flags_i.clr_more;
      default:                    take = 1'b0;
    endcase
    pc_d = take ? ctrl.target : pc_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StClr;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hw/rtl/lpr_dpath.sv =====
module lpr_dpath #(
  parameter int unsigned MAX_VERTICES = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lpr_pkg::ctrl_t                 ctrl_i,
  output lpr_pkg::flags_t                flags_o,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lpr_pkg::item_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lpr_pkg::result_t               out_data_o,
  input  logic                           cfg_we_i,
  input  logic [lpr_pkg::CountW-1:0]     cfg_data_i
);

  localparam int unsigned IdW    = lpr_pkg::IdW;
  localparam int unsigned CountW = lpr_pkg::CountW;
  localparam int unsigned RoundW = lpr_pkg::RoundW;
  localparam int unsigned AddrW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW     = ($clog2(MAX_VERTICES + 1) > CountW) ?
                                   $clog2(MAX_VERTICES + 1) : CountW;

  function automatic logic [AddrW-1:0] id_addr(input logic [IdW-1:0] id);
    logic [IdW+AddrW-1:0] wide;
    wide = {{AddrW{1'b0}}, id};
    return wide[AddrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] cnt_addr(input logic [CountW-1:0] cnt);
    logic [CountW+AddrW-1:0] wide;
    wide = {{AddrW{1'b0}}, cnt};
    return wide[AddrW-1:0];
  endfunction

  // vertex store
  logic [IdW-1:0]    deg_mem  [MAX_VERTICES];
  logic [IdW-1:0]    xor_mem  [MAX_VERTICES];
  logic [RoundW-1:0] mark_mem [MAX_VERTICES];

  logic [IdW-1:0]    deg_rd_q, xor_rd_q;
  logic [RoundW-1:0] mark_rd_q;

  logic [CountW-1:0] vcount_q;
  logic [AddrW-1:0]  clr_cnt_q;
  logic [CountW-1:0] v_q;
  logic [RoundW-1:0] rounds_q;
  logic              removed_q;
  logic              err_q;
  logic              out_valid_q;
  lpr_pkg::item_t    item_q;
  lpr_pkg::result_t  out_q;
  logic [IdW-1:0]    x_q;
  logic              x_ok_q;

  logic [NW-1:0]     vc_wide, n_wide;
  logic [CountW-1:0] n_eff;
  logic [RoundW-1:0] tag;
  logic              in_bad, item_bad, out_busy, out_load, accept;

  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic              we_deg, we_xor, we_mark;
  logic [IdW-1:0]    deg_wd, xor_wd;
  logic [RoundW-1:0] mark_wd;

  assign vc_wide = NW'(vcount_q);
  assign n_wide  = (vc_wide < NW'(MAX_VERTICES)) ? vc_wide : NW'(MAX_VERTICES);
  assign n_eff   = n_wide[CountW-1:0];
  assign tag     = rounds_q + 7'd1;

  assign in_bad = in_data_i.edge_present &&
                  (({1'b0, in_data_i.endpoint_a} >= n_eff) ||
                   ({1'b0, in_data_i.endpoint_b} >= n_eff) ||
                   (in_data_i.endpoint_a == in_data_i.endpoint_b));
  assign item_bad = ({1'b0, item_q.endpoint_a} >= n_eff) ||
                    ({1'b0, item_q.endpoint_b} >= n_eff) ||
                    (item_q.endpoint_a == item_q.endpoint_b);

  assign in_ready_o = (ctrl_i.op == lpr_pkg::OP_ACCEPT);
  assign accept     = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign out_load   = (ctrl_i.op == lpr_pkg::OP_EMIT) && !out_busy;

  assign flags_o.no_req       = !in_valid_i;
  assign flags_o.edge_skip    = !item_q.edge_present || item_bad;
  assign flags_o.not_last     = !item_q.last_item;
  assign flags_o.round_limit  = (rounds_q == lpr_pkg::RoundMax);
  assign flags_o.scan_done    = (v_q >= n_eff);
  assign flags_o.not_elig     = (deg_rd_q != 7'd1) || (mark_rd_q == tag);
  assign flags_o.none_removed = !removed_q;
  assign flags_o.out_busy     = out_busy;
  assign flags_o.clr_more     = (clr_cnt_q != AddrW'(MAX_VERTICES - 1));

  always_comb begin
    unique case (ctrl_i.rd)
      lpr_pkg::RD_A: rd_addr = id_addr(item_q.endpoint_a);
      lpr_pkg::RD_B: rd_addr = id_addr(item_q.endpoint_b);
      lpr_pkg::RD_V: rd_addr = cnt_addr(v_q);
      lpr_pkg::RD_X: rd_addr = id_addr(xor_rd_q);
      default:       rd_addr = cnt_addr(v_q);
    endcase
  end

  always_comb begin
    wr_addr = cnt_addr(v_q);
    we_deg  = 1'b0;
    we_xor  = 1'b0;
    we_mark = 1'b0;
    deg_wd  = '0;
    xor_wd  = '0;
    mark_wd = '0;
    unique case (ctrl_i.wr)
      lpr_pkg::WR_NONE: begin
      end
      lpr_pkg::WR_CLR: begin
        wr_addr = clr_cnt_q;
        we_deg  = 1'b1;
        we_xor  = 1'b1;
        we_mark = 1'b1;
      end
      lpr_pkg::WR_A: begin
        wr_addr = id_addr(item_q.endpoint_a);
        we_deg  = 1'b1;
        we_xor  = 1'b1;
        deg_wd  = deg_rd_q + 7'd1;
        xor_wd  = xor_rd_q ^ item_q.endpoint_b;
      end
      lpr_pkg::WR_B: begin
        wr_addr = id_addr(item_q.endpoint_b);
        we_deg  = 1'b1;
        we_xor  = 1'b1;
        deg_wd  = deg_rd_q + 7'd1;
        xor_wd  = xor_rd_q ^ item_q.endpoint_a;
      end
      lpr_pkg::WR_X: begin
        wr_addr = id_addr(x_q);
        we_deg  = x_ok_q;
        we_xor  = x_ok_q;
        we_mark = x_ok_q;
        deg_wd  = deg_rd_q - 7'd1;
        xor_wd  = xor_rd_q ^ v_q[IdW-1:0];
        mark_wd = tag;
      end
      lpr_pkg::WR_V: begin
        we_deg = 1'b1;
        we_xor = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_deg) begin
      deg_mem[wr_addr] <= deg_wd;
    end
    if (we_xor) begin
      xor_mem[wr_addr] <= xor_wd;
    end
    if (we_mark) begin
      mark_mem[wr_addr] <= mark_wd;
    end
    deg_rd_q  <= deg_mem[rd_addr];
    xor_rd_q  <= xor_mem[rd_addr];
    mark_rd_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (ctrl_i.op == lpr_pkg::OP_LATCH_X) begin
      x_q    <= xor_rd_q;
      x_ok_q <= ({1'b0, xor_rd_q} < n_eff);
    end
    if (out_load) begin
      out_q.round_count <= rounds_q;
      out_q.bad_input   <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= lpr_pkg::CountReset;
      clr_cnt_q   <= '0;
      v_q         <= '0;
      rounds_q    <= '0;
      removed_q   <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_data_i;
      end
      if (ctrl_i.wr == lpr_pkg::WR_V) begin
        removed_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (ctrl_i.op)
        lpr_pkg::OP_NONE: begin
        end
        lpr_pkg::OP_ACCEPT: begin
          if (accept && in_bad) begin
            err_q <= 1'b1;
          end
        end
        lpr_pkg::OP_CLR_INC: begin
          clr_cnt_q <= clr_cnt_q + AddrW'(1);
        end
        lpr_pkg::OP_ROUND_INIT: begin
          v_q       <= '0;
          removed_q <= 1'b0;
        end
        lpr_pkg::OP_LATCH_X: begin
        end
        lpr_pkg::OP_V_INC: begin
          v_q <= v_q + 8'd1;
        end
        lpr_pkg::OP_ROUND_INC: begin
          rounds_q <= rounds_q + 7'd1;
        end
        lpr_pkg::OP_EMIT: begin
        end
        lpr_pkg::OP_RESTART: begin
          clr_cnt_q <= '0;
          rounds_q  <= '0;
          err_q     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_edge_write_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.wr == lpr_pkg::WR_A || ctrl_i.wr == lpr_pkg::WR_B) |->
      (item_q.edge_present && !item_bad))
    else $error("edge written to vertex store without a valid edge");

  a_round_needs_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == lpr_pkg::OP_ROUND_INC) |-> removed_q)
    else $error("round counted without a removal");

  a_tag_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == lpr_pkg::OP_LATCH_X) |-> (rounds_q != lpr_pkg::RoundMax))
    else $error("scan running past the round limit");

endmodule
